/* sv/frequency_of_frequency_counter_defines.svh */
// ----------------------------------------------------------------------------
// frequency_of_frequency_counter_defines
// Assertion macros shared by the checker of the count-of-counts engine.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_OF_FREQUENCY_COUNTER_DEFINES_SVH
`define FREQUENCY_OF_FREQUENCY_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FFC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffc assertion failed");

// Next-cycle implication, disabled during reset.
`define FFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffc assertion failed");

`endif

/* sv/ffc_pkg.sv */
// ----------------------------------------------------------------------------
// ffc_pkg
// Field widths, operation codes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ffc_pkg;

  localparam int OP_W    = 2;
  localparam int COLOR_W = 10;
  localparam int THR_W   = 10;
  localparam int ANS_W   = 11;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_CUR,
    S_NXT,
    S_FIN,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic occ_rd;
    logic cur_step;
    logic nxt_step;
    logic fin_step;
    logic scan_rd;
    logic set_err;
    logic res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic            clr_last;
    logic [OP_W-1:0] op;
    logic            color_bad;
    logic            upd_bad;
    logic            thr_high;
    logic            scan_last;
    logic            res_busy;
  } dp_status_t;

endpackage

/* sv/ffc_ifs.sv */
// ----------------------------------------------------------------------------
// ffc_ifs
// Valid/ready channels for items entering and results leaving the engine.
// ----------------------------------------------------------------------------
interface ffc_in_if;
  import ffc_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [COLOR_W-1:0] color;
  logic [THR_W-1:0]   threshold;

  modport source (output valid, output op, output color, output threshold, input ready);
  modport sink (input valid, input op, input color, input threshold, output ready);
endinterface

interface ffc_out_if;
  import ffc_pkg::*;

  logic             valid;
  logic             ready;
  logic [ANS_W-1:0] colors_at_least;
  logic             error;

  modport source (output valid, output colors_at_least, output error, input ready);
  modport sink (input valid, input colors_at_least, input error, output ready);
endinterface

/* sv/ffc_ram.sv */
// ----------------------------------------------------------------------------
// ffc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ffc_ctrl.sv */
// ----------------------------------------------------------------------------
// ffc_ctrl
// Sequencer: clearing pass, item decode, read-modify-write steps, bucket
// scan and result hand-off.
// ----------------------------------------------------------------------------
module ffc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ffc_pkg::dp_status_t status_i,
  output ffc_pkg::ctrl_cmd_t  cmd_o
);
  import ffc_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_FETCH;
        end
      end
      S_FETCH: begin
        case (status_i.op) inside
          OP_ADD, OP_REMOVE: begin
            if (status_i.color_bad) begin
              cmd_o.set_err = 1'b1;
              state_d       = S_DONE;
            end else begin
              cmd_o.occ_rd = 1'b1;
              state_d      = S_CUR;
            end
          end
          OP_QUERY: begin
            state_d = status_i.thr_high ? S_DONE : S_SCAN;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_CUR: begin
        if (status_i.upd_bad) begin
          cmd_o.set_err = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.cur_step = 1'b1;
          state_d        = S_NXT;
        end
      end
      S_NXT: begin
        cmd_o.nxt_step = 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin_step = 1'b1;
        state_d        = S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!status_i.res_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

/* sv/ffc_datapath.sv */
// ----------------------------------------------------------------------------
// ffc_datapath
// Occurrence and histogram memories, item registers, scan pointer,
// accumulator, clear counter and the output register.
// ----------------------------------------------------------------------------
module ffc_datapath #(
  parameter int NUM_COLORS = 1024,
  parameter int MAX_COUNT  = 1023
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ffc_pkg::ctrl_cmd_t           cmd_i,
  output ffc_pkg::dp_status_t          status_o,
  input  logic [ffc_pkg::OP_W-1:0]     in_op_i,
  input  logic [ffc_pkg::COLOR_W-1:0]  in_color_i,
  input  logic [ffc_pkg::THR_W-1:0]    in_thr_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [ffc_pkg::ANS_W-1:0]    out_ans_o,
  output logic                         out_err_o
);
  import ffc_pkg::*;

  localparam int AW        = $clog2(NUM_COLORS);
  localparam int CW        = $clog2(MAX_COUNT + 1);
  localparam int HW        = $clog2(NUM_COLORS + 1);
  localparam int CLR_DEPTH = (NUM_COLORS > MAX_COUNT + 1) ? NUM_COLORS : MAX_COUNT + 1;
  localparam int CLRW      = $clog2(CLR_DEPTH);

  logic [OP_W-1:0]    op_q;
  logic [COLOR_W-1:0] color_q;
  logic [THR_W-1:0]   thr_q;
  logic [THR_W-1:0]   thr_eff;
  logic [CW-1:0]      cnt_q;
  logic [CW-1:0]      ptr_q;
  logic [HW-1:0]      acc_q;
  logic               acc_pend_q;
  logic               err_q;
  logic [CLRW-1:0]    clr_q;
  logic               res_valid_q;
  logic [ANS_W-1:0]   res_ans_q;
  logic               res_err_q;

  logic [AW-1:0]      occ_addr;
  logic               occ_we;
  logic [AW-1:0]      occ_waddr;
  logic [CW-1:0]      occ_wdata;
  logic [CW-1:0]      occ_rdata;
  logic [CW-1:0]      upd_cnt;
  logic [CW-1:0]      nxt_cnt;
  logic               hist_we;
  logic [CW-1:0]      hist_waddr;
  logic [HW-1:0]      hist_wdata;
  logic               hist_re;
  logic [CW-1:0]      hist_raddr;
  logic [HW-1:0]      hist_rdata;
  logic               is_add;

  assign thr_eff  = (in_thr_i == '0) ? THR_W'(1) : in_thr_i;
  assign occ_addr = AW'(color_q);
  assign is_add   = (op_q == OP_ADD);
  assign upd_cnt  = is_add ? occ_rdata + CW'(1) : occ_rdata - CW'(1);
  assign nxt_cnt  = is_add ? cnt_q + CW'(1) : cnt_q - CW'(1);

  always_comb begin
    occ_we    = (cmd_i.clr_step && (int'(clr_q) < NUM_COLORS)) || cmd_i.cur_step;
    occ_waddr = cmd_i.clr_step ? AW'(clr_q) : occ_addr;
    occ_wdata = cmd_i.clr_step ? '0 : upd_cnt;

    hist_we = (cmd_i.clr_step && (int'(clr_q) <= MAX_COUNT))
            || (cmd_i.nxt_step && (cnt_q != '0))
            || (cmd_i.fin_step && (nxt_cnt != '0));
    if (cmd_i.clr_step) begin
      hist_waddr = CW'(clr_q);
      hist_wdata = '0;
    end else if (cmd_i.nxt_step) begin
      hist_waddr = cnt_q;
      hist_wdata = hist_rdata - HW'(1);
    end else begin
      hist_waddr = nxt_cnt;
      hist_wdata = hist_rdata + HW'(1);
    end

    hist_re = cmd_i.cur_step || cmd_i.nxt_step || cmd_i.scan_rd;
    if (cmd_i.cur_step) begin
      hist_raddr = occ_rdata;
    end else if (cmd_i.nxt_step) begin
      hist_raddr = nxt_cnt;
    end else begin
      hist_raddr = ptr_q;
    end
  end

  ffc_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_COLORS)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .re_i    (cmd_i.occ_rd),
    .raddr_i (occ_addr),
    .rdata_o (occ_rdata)
  );

  ffc_ram #(
    .WIDTH (HW),
    .DEPTH (MAX_COUNT + 1)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_op_i;
      color_q <= in_color_i;
      thr_q   <= thr_eff;
      ptr_q   <= CW'(thr_eff);
      acc_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      if (cmd_i.set_err) begin
        err_q <= 1'b1;
      end
      if (cmd_i.scan_rd) begin
        ptr_q <= ptr_q + CW'(1);
      end
      if (acc_pend_q) begin
        acc_q <= acc_q + hist_rdata;
      end
    end
    if (cmd_i.cur_step) begin
      cnt_q <= occ_rdata;
    end
    if (cmd_i.res_load) begin
      res_ans_q <= ANS_W'(acc_q);
      res_err_q <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      acc_pend_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + CLRW'(1);
      end
      acc_pend_q <= cmd_i.scan_rd;
      if (cmd_i.res_load) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o.clr_last  = (clr_q == CLRW'(CLR_DEPTH - 1));
    status_o.op        = op_q;
    status_o.color_bad = (int'(color_q) >= NUM_COLORS);
    status_o.upd_bad   = is_add ? (int'(occ_rdata) >= MAX_COUNT) : (occ_rdata == '0);
    status_o.thr_high  = (int'(thr_q) > MAX_COUNT);
    status_o.scan_last = (ptr_q == CW'(MAX_COUNT));
    status_o.res_busy  = res_valid_q && !out_ready_i;
  end

  assign out_valid_o = res_valid_q;
  assign out_ans_o   = res_ans_q;
  assign out_err_o   = res_err_q;

endmodule

/* sv/frequency_of_frequency_counter.sv */
// ----------------------------------------------------------------------------
// frequency_of_frequency_counter
// Count-of-counts engine: per-colour occurrence counts and a histogram of
// how many colours hold each count, with add, remove and threshold query.
// ----------------------------------------------------------------------------
// After reset the block sweeps both memories to zero, one entry per cycle,
// over max(NUM_COLORS, MAX_COUNT + 1) addresses (1024 at the defaults);
// in_i.ready stays low until the sweep ends. One item is worked on at a time.
// An add or remove is a read-modify-write on the occurrence RAM and two on
// the histogram RAM, each with a registered read port, done in S_FETCH,
// S_CUR, S_NXT and S_FIN; S_DONE then loads the result into the output
// register, waiting while an earlier result is still held. A query reads
// one histogram bucket per cycle from the threshold up to MAX_COUNT in
// S_SCAN; a threshold above MAX_COUNT, an unused op or an error skips to
// S_DONE. The output register lets the next item be accepted while a
// result still waits.
module frequency_of_frequency_counter #(
  parameter int NUM_COLORS = 1024,
  parameter int MAX_COUNT  = 1023
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffc_in_if.sink     in_i,
  ffc_out_if.source  out_o
);
  import ffc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ffc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ffc_datapath #(
    .NUM_COLORS (NUM_COLORS),
    .MAX_COUNT  (MAX_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_op_i     (in_i.op),
    .in_color_i  (in_i.color),
    .in_thr_i    (in_i.threshold),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_ans_o   (out_o.colors_at_least),
    .out_err_o   (out_o.error)
  );

endmodule

/* sv/ffc_checker.sv */
// ----------------------------------------------------------------------------
// ffc_checker
// Port-level checks of the count-of-counts engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "frequency_of_frequency_counter_defines.svh"

module ffc_checker #(
  parameter int NUM_COLORS = 1024
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ffc_pkg::ANS_W-1:0]   out_ans_i,
  input logic                        out_err_i
);
  import ffc_pkg::*;

  logic [2:0] outst_q;
  logic       in_acc;
  logic       out_acc;
  logic       out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_acc   = out_valid_i && out_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  `FFC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable({out_ans_i, out_err_i}))
  `FFC_ASSERT_IMPLY(a_err_no_ans, clk_i, rst_ni, out_valid_i && out_err_i, out_ans_i == '0)
  `FFC_ASSERT_IMPLY(a_ans_bound, clk_i, rst_ni, out_valid_i, int'(out_ans_i) <= NUM_COLORS)
  `FFC_ASSERT_IMPLY(a_no_orphan, clk_i, rst_ni, out_valid_i, outst_q != 3'd0)
  `FFC_ASSERT_IMPLY(a_outst_max, clk_i, rst_ni, 1'b1, outst_q <= 3'd2)

endmodule

bind frequency_of_frequency_counter ffc_checker #(
  .NUM_COLORS (NUM_COLORS)
) u_ffc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_ans_i   (out_o.colors_at_least),
  .out_err_i   (out_o.error)
);

/* sim/frequency_of_frequency_counter_tb.sv */
// ----------------------------------------------------------------------------
// frequency_of_frequency_counter_tb
// Self-checking bench for the count-of-counts engine. Adds, removes and
// threshold queries go in over the input channel. A local tally of
// per-colour counts and the count histogram predicts every result. The
// bench runs directed corners, a walk of one colour to saturation, a long
// output hold-off and a random mix, with random idle gaps on both sides.
// ----------------------------------------------------------------------------
module frequency_of_frequency_counter_tb;
  import ffc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_COLORS = 1024;
  localparam int MAX_COUNT  = 1023;
  localparam int DRAIN_CYCLES = MAX_COUNT + 100;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [ANS_W-1:0] colors_at_least;
    logic             error;
  } ffc_result_t;

  logic clk_i;
  logic rst_ni;

  ffc_in_if  in_ch ();
  ffc_out_if out_ch ();

  frequency_of_frequency_counter #(
    .NUM_COLORS(NUM_COLORS),
    .MAX_COUNT (MAX_COUNT)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  bit [COLOR_W-1:0] occ_tally  [NUM_COLORS];
  bit [ANS_W-1:0]   hist_tally [MAX_COUNT + 1];

  ffc_result_t pending_results[$];
  int          mismatch_count;
  bit          calm;
  int          hold_off_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic ffc_result_t apply_to_tally(input logic [OP_W-1:0] op,
                                                 input logic [COLOR_W-1:0] color,
                                                 input logic [THR_W-1:0] thr);
    ffc_result_t      res;
    bit [COLOR_W-1:0] cnt;
    int unsigned      sum;
    int unsigned      lo;
    res = '0;
    sum = 0;
    cnt = occ_tally[color];
    case (op)
      OP_ADD: begin
        if (cnt == MAX_COUNT) begin
          res.error = 1'b1;
        end else begin
          if (cnt != 0) hist_tally[cnt] = hist_tally[cnt] - 1'b1;
          occ_tally[color] = cnt + 1'b1;
          hist_tally[cnt + 1'b1] = hist_tally[cnt + 1'b1] + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (cnt == 0) begin
          res.error = 1'b1;
        end else begin
          hist_tally[cnt] = hist_tally[cnt] - 1'b1;
          occ_tally[color] = cnt - 1'b1;
          if (cnt != 1) hist_tally[cnt - 1'b1] = hist_tally[cnt - 1'b1] + 1'b1;
        end
      end
      OP_QUERY: begin
        lo = (thr == 0) ? 1 : 32'(thr);
        for (int j = int'(lo); j <= MAX_COUNT; j++) sum += hist_tally[j];
        res.colors_at_least = sum[ANS_W-1:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [COLOR_W-1:0] color,
                           input logic [THR_W-1:0] thr);
    int          gap;
    ffc_result_t expected;
    gap = (!calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.color     <= color;
    in_ch.threshold <= thr;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    expected = apply_to_tally(op, color, thr);
    pending_results = {pending_results, expected};
  endtask

  task automatic test_directed();
    send_item(OP_QUERY, 10'd0, 10'd1);
    send_item(OP_QUERY, 10'h3FF, 10'd0);
    send_item(OP_QUERY, 10'd0, 10'd1023);
    send_item(OP_REMOVE, 10'd0, 10'd0);
    send_item(OP_ADD, 10'd0, 10'h3FF);
    send_item(OP_ADD, 10'd1023, 10'd0);
    send_item(OP_ADD, 10'd1023, 10'h155);
    send_item(OP_ADD, 10'h155, 10'h2AA);
    send_item(OP_ADD, 10'h2AA, 10'h155);
    send_item(OP_QUERY, 10'd0, 10'd1);
    send_item(OP_QUERY, 10'd0, 10'd2);
    send_item(OP_QUERY, 10'd0, 10'd0);
    send_item(OP_QUERY, 10'h2AA, 10'd3);
    send_item(OP_UNUSED, 10'h3FF, 10'h3FF);
    send_item(OP_UNUSED, 10'd0, 10'd0);
    send_item(OP_REMOVE, 10'd1023, 10'd0);
    send_item(OP_REMOVE, 10'd1023, 10'd0);
    send_item(OP_REMOVE, 10'd1023, 10'h3FF);
    send_item(OP_REMOVE, 10'h155, 10'd0);
    send_item(OP_QUERY, 10'd0, 10'd1);
    send_item(OP_QUERY, 10'd0, 10'd1023);
  endtask

  task automatic test_saturation();
    logic [COLOR_W-1:0] sat_color;
    sat_color = COLOR_W'($urandom_range(0, NUM_COLORS - 1));
    for (int i = 0; i <= MAX_COUNT + 1; i++) begin
      send_item(OP_ADD, sat_color, THR_W'($urandom_range(0, 1023)));
      if (i % 128 == 127) begin
        send_item(OP_QUERY, COLOR_W'($urandom), THR_W'($urandom_range(990, 1023)));
      end
    end
    send_item(OP_QUERY, 10'd0, 10'd1023);
    send_item(OP_REMOVE, sat_color, 10'd0);
    send_item(OP_QUERY, 10'd0, 10'd1023);
    send_item(OP_QUERY, 10'd0, 10'd1022);
    send_item(OP_ADD, sat_color, 10'd0);
    send_item(OP_ADD, sat_color, 10'd0);
    send_item(OP_QUERY, 10'd0, 10'd1023);
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    hold_off_cycles = 400;
    for (int i = 0; i < 12; i++) begin
      if (i == 6) begin
        send_item(OP_QUERY, COLOR_W'($urandom), THR_W'($urandom_range(1010, 1023)));
      end else begin
        send_item((i % 3 == 2) ? OP_REMOVE : OP_ADD, COLOR_W'($urandom_range(0, 7)),
                  THR_W'($urandom));
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_random();
    logic [COLOR_W-1:0] pool_base;
    logic [OP_W-1:0]    op;
    logic [COLOR_W-1:0] color;
    logic [THR_W-1:0]   thr;
    int                 r;
    pool_base = COLOR_W'($urandom_range(0, NUM_COLORS - 16));
    for (int i = 0; i < 760; i++) begin
      if (i % 100 == 0) begin
        calm = ($urandom_range(0, 99) < 25);
        pool_base = COLOR_W'($urandom_range(0, NUM_COLORS - 16));
      end
      r = $urandom_range(0, 99);
      if (r < 45) op = OP_ADD;
      else if (r < 78) op = OP_REMOVE;
      else if (r < 97) op = OP_QUERY;
      else op = OP_UNUSED;
      color = ($urandom_range(0, 99) < 85) ? pool_base + COLOR_W'($urandom_range(0, 15))
                                            : COLOR_W'($urandom_range(0, NUM_COLORS - 1));
      r = $urandom_range(0, 99);
      if (r < 10) thr = '0;
      else if (r < 65) thr = THR_W'($urandom_range(1, 8));
      else thr = THR_W'($urandom);
      send_item(op, color, thr);
    end
    calm = 1'b0;
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        stall_left = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    ffc_result_t want;
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, colors_at_least %0d error %0b",
                 $time, out_ch.colors_at_least, out_ch.error);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.colors_at_least !== want.colors_at_least) begin
          $display("%0t: colors_at_least expected %0d actual %0d",
                   $time, want.colors_at_least, out_ch.colors_at_least);
          mismatch_count++;
        end
        if (out_ch.error !== want.error) begin
          $display("%0t: error expected %0b actual %0b", $time, want.error, out_ch.error);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #250ms;
    $display("frequency_of_frequency_counter_tb NOT OK");
    $finish;
  end

  initial begin
    mismatch_count  = 0;
    calm            = 1'b0;
    hold_off_cycles = 0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_ADD;
    in_ch.color     = '0;
    in_ch.threshold = '0;
    rst_ni          = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_saturation();
    test_backpressure();
    test_random();

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("frequency_of_frequency_counter_tb OK");
    end else begin
      $display("frequency_of_frequency_counter_tb NOT OK");
    end
    $finish;
  end

endmodule
